/* src/apm_pkg.sv */
// Shared types and constants for the amplifier protection monitor.
// No dependencies; used by the top level and the port checker.
`timescale 1ns / 1ps
`default_nettype none

package apm_pkg;

  localparam int unsigned GRACE_SECONDS      = 10;
  localparam int unsigned SECONDS_PER_MINUTE = 60;

  localparam int unsigned TEMP_W  = 8;
  localparam int unsigned CFG_W   = 8;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned FLAGS_W = 6;

  // reset values of the configuration registers
  localparam logic [CFG_W-1:0] RST_SWITCH_OFF_TEMP = 8'd85;
  localparam logic [CFG_W-1:0] RST_WARNING_TEMP    = 8'd75;
  localparam logic [CFG_W-1:0] RST_TIMEOUT_MIN     = 8'd5;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_POWER  = 2'd1,
    ACT_BUTTON = 2'd2,
    ACT_DC     = 2'd3
  } action_t;

  typedef enum logic [IDX_W-1:0] {
    REG_SWITCH_OFF_TEMP = 3'd0,
    REG_WARNING_TEMP    = 3'd1,
    REG_TIMEOUT_MIN     = 3'd2,
    REG_AUTO_OFF_EN     = 3'd3,
    REG_BUTTON_RELOAD   = 3'd4,
    REG_DC_PROT_EN      = 3'd5
  } reg_idx_t;

  // bit positions in the status flag word
  localparam int unsigned FLAG_OK    = 0;
  localparam int unsigned FLAG_FUSE  = 1;
  localparam int unsigned FLAG_TIMER = 2;
  localparam int unsigned FLAG_HOT   = 3;
  localparam int unsigned FLAG_WARN  = 4;
  localparam int unsigned FLAG_DC    = 5;

  typedef logic [FLAGS_W-1:0] flags_t;

  typedef struct packed {
    logic   amp_on;
    logic   transformer_on;
    logic   speakers_on;
    flags_t flags;
  } result_t;

endpackage

`default_nettype wire

/* src/amplifier_protection_monitor.sv */
// Amplifier protection monitor: one event in, one status item out.
// Throughput: one item per cycle while out_stall does not hold the result;
// an input register and a result register bracket a single pass of update
// logic against the relay/flag/countdown state.
// Reset (rst_n low, synchronous): amplifier off, relays released, flags and
// countdown cleared, configuration back to 85/75/5 minutes and all enables set.
// Depends on apm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module amplifier_protection_monitor (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // configuration write port
  input  wire logic                             cfg_wr_en,
  input  wire logic [apm_pkg::IDX_W-1:0]        cfg_index,
  input  wire logic [apm_pkg::CFG_W-1:0]        cfg_data,
  // event channel
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [1:0]                       in_action,
  input  wire logic                             in_signal_present,
  input  wire logic                             in_fuse_left_ok,
  input  wire logic                             in_fuse_right_ok,
  input  wire logic signed [apm_pkg::TEMP_W-1:0] in_temp_left,
  input  wire logic signed [apm_pkg::TEMP_W-1:0] in_temp_right,
  // status channel
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  out_amp_on,
  output logic                                  out_transformer_on,
  output logic                                  out_speakers_on,
  output logic                                  out_status_ok,
  output logic                                  out_fuse_fault,
  output logic                                  out_countdown_running,
  output logic                                  out_overheat_fault,
  output logic                                  out_temp_warning,
  output logic                                  out_dc_fault
);

  localparam int unsigned CW = apm_pkg::CNT_W;

  // configuration
  logic [apm_pkg::CFG_W-1:0] cfg_off_temp_r;
  logic [apm_pkg::CFG_W-1:0] cfg_warn_temp_r;
  logic [apm_pkg::CFG_W-1:0] cfg_timeout_r;
  logic                      cfg_auto_off_r;
  logic                      cfg_btn_reload_r;
  logic                      cfg_dc_en_r;

  // state
  logic            powered_r, powered_nxt;
  logic            xfmr_r, xfmr_nxt;
  logic            spk_r, spk_nxt;
  apm_pkg::flags_t flags_r, flags_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  // input register
  logic                              s1_valid_r, s1_valid_nxt;
  apm_pkg::action_t                  s1_action_r;
  logic                              s1_sig_r;
  logic                              s1_fuse_l_r;
  logic                              s1_fuse_r_r;
  logic signed [apm_pkg::TEMP_W-1:0] s1_temp_l_r;
  logic signed [apm_pkg::TEMP_W-1:0] s1_temp_r_r;

  // result register
  logic             out_valid_r, out_valid_nxt;
  apm_pkg::result_t res_r, res_nxt;

  logic in_accept;
  logic advance;

  logic [CW-1:0] threshold;
  logic [CW-1:0] reload_val;

  logic signed [apm_pkg::TEMP_W:0] tl_ext, tr_ext, off_ext, warn_ext;
  logic hot_hit, warn_hit;
  logic do_check, power_up;

  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  assign threshold  = CW'(cfg_timeout_r) * CW'(apm_pkg::SECONDS_PER_MINUTE);
  assign reload_val = threshold + CW'(apm_pkg::GRACE_SECONDS);

  // signed compare of heatsink readings against unsigned thresholds
  assign tl_ext   = {s1_temp_l_r[apm_pkg::TEMP_W-1], s1_temp_l_r};
  assign tr_ext   = {s1_temp_r_r[apm_pkg::TEMP_W-1], s1_temp_r_r};
  assign off_ext  = $signed({1'b0, cfg_off_temp_r});
  assign warn_ext = $signed({1'b0, cfg_warn_temp_r});
  assign hot_hit  = (tl_ext >= off_ext) || (tr_ext >= off_ext);
  assign warn_hit = (tl_ext >= warn_ext) || (tr_ext >= warn_ext);

  assign power_up = (s1_action_r == apm_pkg::ACT_POWER) && !powered_r;
  assign do_check = ((s1_action_r == apm_pkg::ACT_TICK) && powered_r) || power_up;

  always_comb begin
    powered_nxt = powered_r;
    xfmr_nxt    = xfmr_r;
    spk_nxt     = spk_r;
    flags_nxt   = flags_r;
    cnt_nxt     = cnt_r;

    case (s1_action_r)
      apm_pkg::ACT_TICK: begin
        // check below
      end
      apm_pkg::ACT_POWER: begin
        if (cfg_btn_reload_r) begin
          cnt_nxt = reload_val;
        end
        if (powered_r) begin
          powered_nxt = 1'b0;
          xfmr_nxt    = 1'b0;
          spk_nxt     = 1'b0;
        end else begin
          powered_nxt = 1'b1;
          flags_nxt   = '0;
          cnt_nxt     = reload_val;
        end
      end
      apm_pkg::ACT_BUTTON: begin
        if (cfg_btn_reload_r) begin
          cnt_nxt = reload_val;
        end
      end
      apm_pkg::ACT_DC: begin
        if (cfg_dc_en_r) begin
          flags_nxt[apm_pkg::FLAG_DC] = 1'b1;
          xfmr_nxt = 1'b0;
          spk_nxt  = 1'b0;
        end
      end
      default: begin
      end
    endcase

    if (do_check) begin
      // only the latched faults survive a check
      flags_nxt = flags_nxt & ((apm_pkg::flags_t'(1) << apm_pkg::FLAG_HOT) |
                               (apm_pkg::flags_t'(1) << apm_pkg::FLAG_DC));
      if ((!s1_fuse_l_r || !s1_fuse_r_r) && xfmr_nxt) begin
        flags_nxt[apm_pkg::FLAG_FUSE] = 1'b1;
      end
      if (s1_sig_r) begin
        cnt_nxt = reload_val;
      end else begin
        if (cnt_nxt < threshold) begin
          flags_nxt[apm_pkg::FLAG_TIMER] = 1'b1;
        end
        if (cfg_auto_off_r) begin
          if (cnt_nxt != '0) begin
            cnt_nxt = cnt_nxt - CW'(1);
          end
        end else begin
          cnt_nxt = reload_val;
        end
        if (cnt_nxt == '0) begin
          powered_nxt = 1'b0;
          xfmr_nxt    = 1'b0;
          spk_nxt     = 1'b0;
        end
      end
      if (hot_hit) begin
        flags_nxt[apm_pkg::FLAG_HOT] = 1'b1;
        xfmr_nxt = 1'b0;
        spk_nxt  = 1'b0;
      end else if (warn_hit) begin
        flags_nxt[apm_pkg::FLAG_WARN] = 1'b1;
      end
      if (flags_nxt == '0) begin
        flags_nxt[apm_pkg::FLAG_OK] = 1'b1;
      end
    end

    // relays close at power on unless the check turned the amp off again; an overheat keeps the transformer open
    if (power_up && powered_nxt) begin
      if (!flags_nxt[apm_pkg::FLAG_HOT]) begin
        xfmr_nxt = 1'b1;
      end
      spk_nxt = 1'b1;
    end
  end

  always_comb begin
    res_nxt.amp_on         = powered_nxt;
    res_nxt.transformer_on = xfmr_nxt;
    res_nxt.speakers_on    = spk_nxt;
    res_nxt.flags          = flags_nxt;
  end

  assign s1_valid_nxt  = in_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = advance ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_off_temp_r   <= apm_pkg::RST_SWITCH_OFF_TEMP;
      cfg_warn_temp_r  <= apm_pkg::RST_WARNING_TEMP;
      cfg_timeout_r    <= apm_pkg::RST_TIMEOUT_MIN;
      cfg_auto_off_r   <= 1'b1;
      cfg_btn_reload_r <= 1'b1;
      cfg_dc_en_r      <= 1'b1;
      powered_r        <= 1'b0;
      xfmr_r           <= 1'b0;
      spk_r            <= 1'b0;
      flags_r          <= '0;
      cnt_r            <= '0;
      s1_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (apm_pkg::reg_idx_t'(cfg_index))
          apm_pkg::REG_SWITCH_OFF_TEMP: cfg_off_temp_r   <= cfg_data;
          apm_pkg::REG_WARNING_TEMP:    cfg_warn_temp_r  <= cfg_data;
          apm_pkg::REG_TIMEOUT_MIN:     cfg_timeout_r    <= cfg_data;
          apm_pkg::REG_AUTO_OFF_EN:     cfg_auto_off_r   <= cfg_data[0];
          apm_pkg::REG_BUTTON_RELOAD:   cfg_btn_reload_r <= cfg_data[0];
          apm_pkg::REG_DC_PROT_EN:      cfg_dc_en_r      <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (advance) begin
        powered_r <= powered_nxt;
        xfmr_r    <= xfmr_nxt;
        spk_r     <= spk_nxt;
        flags_r   <= flags_nxt;
        cnt_r     <= cnt_nxt;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_action_r <= apm_pkg::action_t'(in_action);
      s1_sig_r    <= in_signal_present;
      s1_fuse_l_r <= in_fuse_left_ok;
      s1_fuse_r_r <= in_fuse_right_ok;
      s1_temp_l_r <= in_temp_left;
      s1_temp_r_r <= in_temp_right;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_amp_on            = res_r.amp_on;
  assign out_transformer_on    = res_r.transformer_on;
  assign out_speakers_on       = res_r.speakers_on;
  assign out_status_ok         = res_r.flags[apm_pkg::FLAG_OK];
  assign out_fuse_fault        = res_r.flags[apm_pkg::FLAG_FUSE];
  assign out_countdown_running = res_r.flags[apm_pkg::FLAG_TIMER];
  assign out_overheat_fault    = res_r.flags[apm_pkg::FLAG_HOT];
  assign out_temp_warning      = res_r.flags[apm_pkg::FLAG_WARN];
  assign out_dc_fault          = res_r.flags[apm_pkg::FLAG_DC];

endmodule

`default_nettype wire

/* src/apm_checker.sv */
// Port-level checks for the amplifier protection monitor, bound to the top.
// Depends on apm_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

module apm_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              cfg_wr_en,
  input wire logic [apm_pkg::IDX_W-1:0]         cfg_index,
  input wire logic [apm_pkg::CFG_W-1:0]         cfg_data,
  input wire logic                              in_valid,
  input wire logic                              in_stall,
  input wire logic [1:0]                        in_action,
  input wire logic                              in_signal_present,
  input wire logic                              in_fuse_left_ok,
  input wire logic                              in_fuse_right_ok,
  input wire logic signed [apm_pkg::TEMP_W-1:0] in_temp_left,
  input wire logic signed [apm_pkg::TEMP_W-1:0] in_temp_right,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic                              out_amp_on,
  input wire logic                              out_transformer_on,
  input wire logic                              out_speakers_on,
  input wire logic                              out_status_ok,
  input wire logic                              out_fuse_fault,
  input wire logic                              out_countdown_running,
  input wire logic                              out_overheat_fault,
  input wire logic                              out_temp_warning,
  input wire logic                              out_dc_fault
);

  // relays only ever close while the amp is on
  a_relays_need_power: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_transformer_on || out_speakers_on) |-> out_amp_on)
    else $error("relay driven while amplifier off");

  // a latched overheat keeps the transformer off until the next power on
  a_hot_cuts_xfmr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overheat_fault |-> !out_transformer_on)
    else $error("transformer on with overheat latched");

  // ok is only reported when the check found nothing
  a_ok_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status_ok |->
      !out_fuse_fault && !out_countdown_running && !out_overheat_fault &&
      !out_temp_warning)
    else $error("status ok together with a check fault");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_amp_on) &&
      $stable(out_transformer_on) && $stable(out_speakers_on) &&
      $stable(out_status_ok) && $stable(out_dc_fault))
    else $error("stalled result item changed");

endmodule

bind amplifier_protection_monitor apm_checker u_apm_checker (.*);

`default_nettype wire
